// ----- hdl/b64u_pkg.sv -----
package b64u_pkg;

  // Input function codes.
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Register indexes on the configuration port.
  localparam int REG_OUT_LIMIT = 0;

  localparam logic [15:0] OUT_LIMIT_RESET = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [7:0]  CHAR_PAD        = 8'h3D;  // '='
  localparam logic [7:0]  CHAR_NONE       = 8'h00;

  // Number of pending bits left between items.
  localparam logic [2:0] PEND_0 = 3'd0;
  localparam logic [2:0] PEND_2 = 3'd2;
  localparam logic [2:0] PEND_4 = 3'd4;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic        is_last;
    logic        overflow;
    logic [15:0] char_count;
  } out_item_t;

  // Results of one processed input item, handed to the result queue.
  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

  // Maps a 6-bit group to its URL-safe base64 symbol.
  function automatic logic [7:0] b64_char(input logic [5:0] six);
    logic [7:0] wide;
    wide = {2'b00, six};
    if (six < 6'd26) begin
      return 8'h41 + wide;
    end else if (six < 6'd52) begin
      return 8'h61 + wide - 8'd26;
    end else if (six < 6'd62) begin
      return 8'h30 + wide - 8'd52;
    end else if (six == 6'd62) begin
      return 8'h2D;
    end else begin
      return 8'h5F;
    end
  endfunction

  // Character count that stops at its top value.
  function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
    return (cnt == COUNT_MAX) ? cnt : cnt + 16'd1;
  endfunction

  function automatic out_item_t make_res(input logic [7:0] ch, input logic last,
                                         input logic ovf, input logic [15:0] cnt);
    out_item_t r;
    r.char_out   = ch;
    r.is_last    = last;
    r.overflow   = ovf;
    r.char_count = cnt;
    return r;
  endfunction

endpackage

// ----- hdl/base64url_stream_encoder_top.sv -----
// URL-safe base64 stream encoder. Each data transaction shifts one byte in and
// yields one or two alphabet characters; an end transaction yields the final
// padded character if any, then '=' marked last, with the running character
// count. When the count has reached out_limit (reset 65535) before a byte, a pad
// character or the terminator, an overflow result marked last is given instead
// and data is dropped until the next end transaction. An accepted item sits in
// an input register and is encoded once the four-entry result queue has two
// free places; the input register can take a new transaction while the held
// one is encoded. Results leave one per cycle while the output is not stalled,
// and no transaction yields more than two results. A transaction passes
// through the input register, and its results through the result queue,
// before they are offered. The output queue, which gives out one character per
// cycle when not stalled, sets the throughput. out_limit is written over the
// APB port at byte address 0.
module base64url_stream_encoder_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b64u_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b64u_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [15:0]     out_limit;
  logic            room;
  b64u_pkg::push_t push;

  b64u_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .out_limit (out_limit)
  );

  b64u_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_limit (out_limit),
    .room      (room),
    .push      (push)
  );

  b64u_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/b64u_apb.sv -----
module b64u_apb (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] out_limit
);

  logic hit;

  // Register 0 sits at byte address 0; address 4 and up hold nothing.
  assign hit    = (paddr[2] == 1'(b64u_pkg::REG_OUT_LIMIT));
  assign pready = 1'b1;
  assign prdata = hit ? {16'h0000, out_limit} : 32'h0000_0000;

  // Register write on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= b64u_pkg::OUT_LIMIT_RESET;
    end else if (psel && penable && pwrite && hit) begin
      out_limit <= pwdata[15:0];
    end
  end

endmodule

// ----- hdl/b64u_core.sv -----
module b64u_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64u_pkg::in_item_t  in_data,
  input  logic [15:0]         out_limit,
  input  logic                room,
  output b64u_pkg::push_t     push
);

  logic               full;
  logic               full_next;
  b64u_pkg::in_item_t in_item;
  logic               proc;
  logic               accept;

  logic [3:0]  acc;
  logic [3:0]  acc_next;
  logic [2:0]  pend;
  logic [2:0]  pend_next;
  logic [15:0] cnt;
  logic [15:0] cnt_next;
  logic        failed;
  logic        failed_next;

  logic [1:0]          num;
  b64u_pkg::out_item_t res0;
  b64u_pkg::out_item_t res1;

  // The held item is processed once the queue has space for two results.
  assign proc     = full && room;
  assign in_stall = full && !proc;
  assign accept   = in_valid && !in_stall;
  assign full_next = accept ? 1'b1 : (proc ? 1'b0 : full);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= in_data;
    end
  end

  // Encoding step for the held item.
  always_comb begin
    logic [15:0] c1;
    logic [15:0] c2;
    logic        hit0;
    logic        hit1;
    logic [11:0] accw;
    logic [5:0]  pad;
    c1   = b64u_pkg::sat_inc(cnt);
    c2   = b64u_pkg::sat_inc(c1);
    hit0 = (cnt >= out_limit);
    hit1 = (c1 >= out_limit);
    accw = {acc, in_item.data_byte};
    pad  = (pend == b64u_pkg::PEND_2) ? {acc[1:0], 4'b0000} : {acc, 2'b00};
    num         = 2'd0;
    res0        = '0;
    res1        = '0;
    acc_next    = acc;
    pend_next   = pend;
    cnt_next    = cnt;
    failed_next = failed;
    if (in_item.func == b64u_pkg::FUNC_DATA) begin
      if (!failed) begin
        if (hit0) begin
          // Limit reached before this byte: report and drop it.
          num         = 2'd1;
          res0        = b64u_pkg::make_res(b64u_pkg::CHAR_NONE, 1'b1, 1'b1, cnt);
          failed_next = 1'b1;
        end else begin
          unique case (pend)
            b64u_pkg::PEND_2: begin
              num       = 2'd1;
              res0      = b64u_pkg::make_res(b64u_pkg::b64_char(accw[9:4]), 1'b0, 1'b0, c1);
              acc_next  = accw[3:0];
              pend_next = b64u_pkg::PEND_4;
              cnt_next  = c1;
            end
            b64u_pkg::PEND_4: begin
              num       = 2'd2;
              res0      = b64u_pkg::make_res(b64u_pkg::b64_char(accw[11:6]), 1'b0, 1'b0, c1);
              res1      = b64u_pkg::make_res(b64u_pkg::b64_char(accw[5:0]), 1'b0, 1'b0, c2);
              acc_next  = 4'h0;
              pend_next = b64u_pkg::PEND_0;
              cnt_next  = c2;
            end
            default: begin
              num       = 2'd1;
              res0      = b64u_pkg::make_res(b64u_pkg::b64_char(accw[7:2]), 1'b0, 1'b0, c1);
              acc_next  = {2'b00, accw[1:0]};
              pend_next = b64u_pkg::PEND_2;
              cnt_next  = c1;
            end
          endcase
        end
      end
    end else begin
      // End of message always returns the state to its cleared form.
      acc_next    = 4'h0;
      pend_next   = b64u_pkg::PEND_0;
      cnt_next    = 16'h0000;
      failed_next = 1'b0;
      if (!failed) begin
        if (pend != b64u_pkg::PEND_0) begin
          if (hit0) begin
            num  = 2'd1;
            res0 = b64u_pkg::make_res(b64u_pkg::CHAR_NONE, 1'b1, 1'b1, cnt);
          end else begin
            num  = 2'd2;
            res0 = b64u_pkg::make_res(b64u_pkg::b64_char(pad), 1'b0, 1'b0, c1);
            if (hit1) begin
              res1 = b64u_pkg::make_res(b64u_pkg::CHAR_NONE, 1'b1, 1'b1, c1);
            end else begin
              res1 = b64u_pkg::make_res(b64u_pkg::CHAR_PAD, 1'b1, 1'b0, c2);
            end
          end
        end else begin
          num = 2'd1;
          if (hit0) begin
            res0 = b64u_pkg::make_res(b64u_pkg::CHAR_NONE, 1'b1, 1'b1, cnt);
          end else begin
            res0 = b64u_pkg::make_res(b64u_pkg::CHAR_PAD, 1'b1, 1'b0, c1);
          end
        end
      end
    end
  end

  // Message state advances only when an item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= 4'h0;
      pend   <= b64u_pkg::PEND_0;
      cnt    <= 16'h0000;
      failed <= 1'b0;
    end else if (proc) begin
      acc    <= acc_next;
      pend   <= pend_next;
      cnt    <= cnt_next;
      failed <= failed_next;
    end
  end

  assign push.num  = proc ? num : 2'd0;
  assign push.res0 = res0;
  assign push.res1 = res1;

endmodule

// ----- hdl/b64u_queue.sv -----
module b64u_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  b64u_pkg::push_t      push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b64u_pkg::out_item_t  out_data
);

  localparam int Depth = 4;

  b64u_pkg::out_item_t mem [Depth];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign out_data  = mem[head];
  assign pop       = out_valid && !out_stall;
  // Space for a full pair of results, not counting this cycle's pop.
  assign room      = (count <= 3'(Depth - 2));

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[tail] <= push.res0;
    end
    if (push.num == 2'd2) begin
      mem[tail + 2'd1] <= push.res1;
    end
  end

  // Pointer and fill level bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      tail  <= tail + push.num;
      head  <= head + {1'b0, pop};
      count <= count + {1'b0, push.num} - {2'b00, pop};
    end
  end

endmodule

// ----- hdl/b64u_checker.sv -----
module b64u_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input b64u_pkg::out_item_t  out_data
);

  // A stalled result stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An overflow result ends the message and carries no character.
  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |-> out_data.is_last &&
      out_data.char_out == b64u_pkg::CHAR_NONE)
    else $error("malformed overflow result");

  // A normal last result is the terminator.
  a_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_last && !out_data.overflow |->
      out_data.char_out == b64u_pkg::CHAR_PAD)
    else $error("last result is not the terminator");

  // Every emitted character is counted.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.overflow |-> out_data.char_count != 16'h0000)
    else $error("character emitted with zero count");

endmodule

bind base64url_stream_encoder_top b64u_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
